>>> rtl/affine_reference_line_update_defines.svh
// Assertion macros for the affine reference line update block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef AFFINE_REFERENCE_LINE_UPDATE_DEFINES_SVH
`define AFFINE_REFERENCE_LINE_UPDATE_DEFINES_SVH

`ifndef SYNTH
`define ARLU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
`define ARLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define ARLU_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ARLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/arlu_pkg.sv
// Shared types, register indexes and helpers for the affine reference line update.
// No dependencies.
package arlu_pkg;

    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned DATA_W    = 64;

    localparam logic [REG_IDX_W-1:0] REG_BG_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOSAIC_EN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BG_MOS_H    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OBJ_MOS_H   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_START     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_START     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_X_STEP      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_Y_STEP      = 3'd7;

    localparam logic [31:0] Y_STEP_RESET = 32'h0100_0100;
    localparam logic [4:0]  MOS_H_MAX    = 5'd16;

    localparam logic KIND_DRAWN = 1'b0;
    localparam logic KIND_BLANK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [8:0] line_number;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] bg2_ref_x;
        logic signed [31:0] bg2_ref_y;
        logic signed [31:0] bg3_ref_x;
        logic signed [31:0] bg3_ref_y;
        logic        [3:0]  bg_mosaic_line;
        logic        [3:0]  obj_mosaic_line;
    } t_out_req;

    // configuration as seen by the datapath, heights already clamped
    typedef struct packed {
        logic             mode_on;
        logic [1:0]       mosaic_en;
        logic [4:0]       bg_h;
        logic [4:0]       obj_h;
        logic [63:0]      x_start;
        logic [63:0]      y_start;
        logic [1:0][31:0] x_step;
        logic [1:0][31:0] y_step;
        logic [1:0][31:0] x_step_scl;
        logic [1:0][31:0] y_step_scl;
    } t_cfg_view;

    function automatic logic [4:0] eff_height(input logic [4:0] h);
        return (h > MOS_H_MAX) ? MOS_H_MAX : h;
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

>>> rtl/arlu_cfg.sv
// Configuration register file with APB-style access and pre-scaled mosaic steps.
// Depends on arlu_pkg.
module arlu_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arlu_pkg::ADDR_W-1:0] paddr,
    input  logic [arlu_pkg::DATA_W-1:0] pwdata,
    output logic [arlu_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output arlu_pkg::t_cfg_view        o_cfg
);
    import arlu_pkg::*;

    logic [2:0]  r_bg_mode,   n_bg_mode;
    logic [1:0]  r_mos_en,    n_mos_en;
    logic [4:0]  r_bg_h,      n_bg_h;
    logic [4:0]  r_obj_h,     n_obj_h;
    logic [63:0] r_x_start,   n_x_start;
    logic [63:0] r_y_start,   n_y_start;
    logic [31:0] r_x_step,    n_x_step;
    logic [31:0] r_y_step,    n_y_step;
    logic [1:0][31:0] r_x_scl, n_x_scl;
    logic [1:0][31:0] r_y_scl, n_y_scl;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [4:0]           n_bg_eff;
    logic signed [21:0]   prod_x [2];
    logic signed [21:0]   prod_y [2];

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:3];

    always_comb begin
        n_bg_mode = r_bg_mode;
        n_mos_en  = r_mos_en;
        n_bg_h    = r_bg_h;
        n_obj_h   = r_obj_h;
        n_x_start = r_x_start;
        n_y_start = r_y_start;
        n_x_step  = r_x_step;
        n_y_step  = r_y_step;
        if (wr_en) begin
            unique case (idx)
                REG_BG_MODE:   n_bg_mode = pwdata[2:0];
                REG_MOSAIC_EN: n_mos_en  = pwdata[1:0];
                REG_BG_MOS_H:  n_bg_h    = pwdata[4:0];
                REG_OBJ_MOS_H: n_obj_h   = pwdata[4:0];
                REG_X_START:   n_x_start = pwdata;
                REG_Y_START:   n_y_start = pwdata;
                REG_X_STEP:    n_x_step  = pwdata[31:0];
                REG_Y_STEP:    n_y_step  = pwdata[31:0];
                default:       n_bg_mode = r_bg_mode;
            endcase
        end
    end

    // height times step, computed from the incoming values so it lands with them
    assign n_bg_eff = eff_height(n_bg_h);
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            prod_x[i]  = $signed({1'b0, n_bg_eff}) * $signed(n_x_step[16*i +: 16]);
            prod_y[i]  = $signed({1'b0, n_bg_eff}) * $signed(n_y_step[16*i +: 16]);
            n_x_scl[i] = {{10{prod_x[i][21]}}, prod_x[i]};
            n_y_scl[i] = {{10{prod_y[i][21]}}, prod_y[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_mode <= '0;
            r_mos_en  <= '0;
            r_bg_h    <= 5'd1;
            r_obj_h   <= 5'd1;
            r_x_start <= '0;
            r_y_start <= '0;
            r_x_step  <= '0;
            r_y_step  <= Y_STEP_RESET;
            r_x_scl   <= '0;
            r_y_scl   <= {Y_STEP_RESET[31:16] == 16'h0100 ? 32'h0000_0100 : 32'h0,
                          32'h0000_0100};
        end else begin
            r_bg_mode <= n_bg_mode;
            r_mos_en  <= n_mos_en;
            r_bg_h    <= n_bg_h;
            r_obj_h   <= n_obj_h;
            r_x_start <= n_x_start;
            r_y_start <= n_y_start;
            r_x_step  <= n_x_step;
            r_y_step  <= n_y_step;
            r_x_scl   <= n_x_scl;
            r_y_scl   <= n_y_scl;
        end
    end

    always_comb begin
        unique case (idx)
            REG_BG_MODE:   prdata = {61'd0, r_bg_mode};
            REG_MOSAIC_EN: prdata = {62'd0, r_mos_en};
            REG_BG_MOS_H:  prdata = {59'd0, r_bg_h};
            REG_OBJ_MOS_H: prdata = {59'd0, r_obj_h};
            REG_X_START:   prdata = r_x_start;
            REG_Y_START:   prdata = r_y_start;
            REG_X_STEP:    prdata = {32'd0, r_x_step};
            REG_Y_STEP:    prdata = {32'd0, r_y_step};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.mode_on    = (r_bg_mode != 3'd0);
        o_cfg.mosaic_en  = r_mos_en;
        o_cfg.bg_h       = eff_height(r_bg_h);
        o_cfg.obj_h      = eff_height(r_obj_h);
        o_cfg.x_start    = r_x_start;
        o_cfg.y_start    = r_y_start;
        o_cfg.x_step[0]  = sext16(r_x_step[15:0]);
        o_cfg.x_step[1]  = sext16(r_x_step[31:16]);
        o_cfg.y_step[0]  = sext16(r_y_step[15:0]);
        o_cfg.y_step[1]  = sext16(r_y_step[31:16]);
        o_cfg.x_step_scl = r_x_scl;
        o_cfg.y_step_scl = r_y_scl;
    end

endmodule

>>> rtl/arlu_core.sv
// Line update datapath: request register, reference/row state and result register.
// Depends on arlu_pkg and the assertion macros header.
`include "affine_reference_line_update_defines.svh"

module arlu_core #(
    parameter int RELOAD_LINE = 192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arlu_pkg::t_cfg_view  i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  arlu_pkg::t_in_req    i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output arlu_pkg::t_out_req   o_out_req
);
    import arlu_pkg::*;

    logic             r_in_vld;
    t_in_req          r_in;
    logic             r_out_vld;
    t_out_req         r_out;
    logic [1:0][31:0] r_ref_x, n_ref_x;
    logic [1:0][31:0] r_ref_y, n_ref_y;
    logic [3:0]       r_bg_row, n_bg_row;
    logic [3:0]       r_obj_row, n_obj_row;

    logic       out_free;
    logic       fire;
    logic       accept;
    logic       reload;
    logic [4:0] bg_inc;
    logic [4:0] obj_inc;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign reload     = (r_in.kind == KIND_BLANK) && (r_in.line_number == 9'(RELOAD_LINE));

    assign bg_inc  = {1'b0, r_bg_row} + 5'd1;
    assign obj_inc = {1'b0, r_obj_row} + 5'd1;

    always_comb begin
        n_ref_x   = r_ref_x;
        n_ref_y   = r_ref_y;
        n_bg_row  = r_bg_row;
        n_obj_row = r_obj_row;
        if (r_in.kind == KIND_DRAWN) begin
            n_bg_row  = (bg_inc  >= i_cfg.bg_h)  ? 4'd0 : bg_inc[3:0];
            n_obj_row = (obj_inc >= i_cfg.obj_h) ? 4'd0 : obj_inc[3:0];
            if (i_cfg.mode_on) begin
                for (int i = 0; i < 2; i++) begin
                    if (i_cfg.mosaic_en[i]) begin
                        if (n_bg_row == 4'd0) begin
                            n_ref_x[i] = r_ref_x[i] + i_cfg.x_step_scl[i];
                            n_ref_y[i] = r_ref_y[i] + i_cfg.y_step_scl[i];
                        end
                    end else begin
                        n_ref_x[i] = r_ref_x[i] + i_cfg.x_step[i];
                        n_ref_y[i] = r_ref_y[i] + i_cfg.y_step[i];
                    end
                end
            end
        end else if (reload) begin
            n_bg_row   = '0;
            n_obj_row  = '0;
            n_ref_x[0] = i_cfg.x_start[31:0];
            n_ref_x[1] = i_cfg.x_start[63:32];
            n_ref_y[0] = i_cfg.y_start[31:0];
            n_ref_y[1] = i_cfg.y_start[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ref_x   <= '0;
            r_ref_y   <= '0;
            r_bg_row  <= '0;
            r_obj_row <= '0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (fire) begin
                r_ref_x   <= n_ref_x;
                r_ref_y   <= n_ref_y;
                r_bg_row  <= n_bg_row;
                r_obj_row <= n_obj_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_req;
        end
        if (fire) begin
            r_out.bg2_ref_x       <= $signed(n_ref_x[0]);
            r_out.bg2_ref_y       <= $signed(n_ref_y[0]);
            r_out.bg3_ref_x       <= $signed(n_ref_x[1]);
            r_out.bg3_ref_y       <= $signed(n_ref_y[1]);
            r_out.bg_mosaic_line  <= n_bg_row;
            r_out.obj_mosaic_line <= n_obj_row;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    `ARLU_ASSERT_SAME(a_stall_needs_pending, i_clk, i_rst_n, o_in_stall, r_in_vld)
    `ARLU_ASSERT_NEXT(a_fire_loads_result, i_clk, i_rst_n, fire, r_out_vld)
    `ARLU_ASSERT_NEXT(a_row_in_range, i_clk, i_rst_n, fire && (r_in.kind == KIND_DRAWN), (({1'b0, r_bg_row} < i_cfg.bg_h) || (r_bg_row == 4'd0)))
    `ARLU_ASSERT_NEXT(a_reload_clears, i_clk, i_rst_n, fire && reload, (r_bg_row == 4'd0) && (r_obj_row == 4'd0) && (r_ref_x[0] == i_cfg.x_start[31:0]))
    `ARLU_ASSERT_NEXT(a_mode_off_holds, i_clk, i_rst_n, fire && (r_in.kind == KIND_DRAWN) && !i_cfg.mode_on, $stable(r_ref_x) && $stable(r_ref_y))

endmodule

>>> rtl/affine_reference_line_update.sv
// Top level of the affine background reference point and mosaic row line update.
// Depends on arlu_pkg, arlu_cfg and arlu_core.
//
//   channel   | valid        | stall        | payload
//   ----------+--------------+--------------+------------------------
//   request   | i_in_valid   | o_in_stall   | i_in_req  (t_in_req)
//   result    | o_out_valid  | i_out_stall  | o_out_req (t_out_req)
//   config    | psel/penable | pready = 1   | paddr, pwdata, prdata
//
// One request per cycle sustained while the result side does not stall; an
// accepted request is held in the request register and its result is loaded
// into the result register. The state update between them is combinational;
// the heights-times-steps products are kept registered.
// Reset is synchronous, active low; registers other than r_in and r_out are reset.
// A stalled result holds the result register; the request side stalls only when
// a request is pending and the result register cannot take it.
module affine_reference_line_update #(
    parameter int RELOAD_LINE = 192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  arlu_pkg::t_in_req           i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output arlu_pkg::t_out_req          o_out_req,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arlu_pkg::ADDR_W-1:0] paddr,
    input  logic [arlu_pkg::DATA_W-1:0] pwdata,
    output logic [arlu_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import arlu_pkg::*;

    t_cfg_view cfg;

    arlu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    arlu_core #(
        .RELOAD_LINE (RELOAD_LINE)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

>>> tb/arlu_ref_checker.sv
// Checker for affine_reference_line_update: predicts reference points and mosaic rows
// from the observed requests and config writes, and compares every accepted result.
// Depends on arlu_pkg.
`timescale 1ns / 1ps

module arlu_ref_checker #(
    parameter int RELOAD_LINE = 192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  arlu_pkg::t_in_req           i_in_req,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  arlu_pkg::t_out_req          i_out_req,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [arlu_pkg::ADDR_W-1:0] i_paddr,
    input  logic [arlu_pkg::DATA_W-1:0] i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import arlu_pkg::*;

    logic [2:0]  bg_mode;
    logic [1:0]  mosaic_en;
    logic [4:0]  bg_height;
    logic [4:0]  obj_height;
    logic [63:0] x_start;
    logic [63:0] y_start;
    logic [31:0] x_step;
    logic [31:0] y_step;

    logic [31:0] ref_x [2];
    logic [31:0] ref_y [2];
    logic [3:0]  bg_row;
    logic [3:0]  obj_row;

    t_out_req line_refs_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [4:0] clamp_height(input logic [4:0] h);
        return (h > 5'd16) ? 5'd16 : h;
    endfunction

    function automatic logic [3:0] next_row(input logic [3:0] row, input logic [4:0] h);
        logic [4:0] nxt;
        nxt = {1'b0, row} + 5'd1;
        return (nxt >= clamp_height(h)) ? 4'd0 : nxt[3:0];
    endfunction

    task automatic write_setting(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            REG_BG_MODE:   bg_mode    = data[2:0];
            REG_MOSAIC_EN: mosaic_en  = data[1:0];
            REG_BG_MOS_H:  bg_height  = data[4:0];
            REG_OBJ_MOS_H: obj_height = data[4:0];
            REG_X_START:   x_start    = data;
            REG_Y_START:   y_start    = data;
            REG_X_STEP:    x_step     = data[31:0];
            REG_Y_STEP:    y_step     = data[31:0];
            default: ;
        endcase
    endtask

    task automatic step_line(input t_in_req req, output t_out_req res);
        int          b;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] mul;
        if (req.kind == KIND_DRAWN) begin
            bg_row  = next_row(bg_row, bg_height);
            obj_row = next_row(obj_row, obj_height);
            if (bg_mode != 3'd0) begin
                for (b = 0; b < 2; b++) begin
                    sx = x_step[16*b +: 16];
                    sy = y_step[16*b +: 16];
                    dx = {{16{sx[15]}}, sx};
                    dy = {{16{sy[15]}}, sy};
                    if (mosaic_en[b]) begin
                        if (bg_row == 4'd0) begin
                            mul      = {27'd0, clamp_height(bg_height)};
                            ref_x[b] = ref_x[b] + mul * dx;
                            ref_y[b] = ref_y[b] + mul * dy;
                        end
                    end else begin
                        ref_x[b] = ref_x[b] + dx;
                        ref_y[b] = ref_y[b] + dy;
                    end
                end
            end
        end else if (req.line_number == 9'(RELOAD_LINE)) begin
            bg_row   = 4'd0;
            obj_row  = 4'd0;
            ref_x[0] = x_start[31:0];
            ref_x[1] = x_start[63:32];
            ref_y[0] = y_start[31:0];
            ref_y[1] = y_start[63:32];
        end
        res.bg2_ref_x       = ref_x[0];
        res.bg2_ref_y       = ref_y[0];
        res.bg3_ref_x       = ref_x[1];
        res.bg3_ref_y       = ref_y[1];
        res.bg_mosaic_line  = bg_row;
        res.obj_mosaic_line = obj_row;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (o_fail_count < 10)
                $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req predicted;
        t_out_req want;
        if (!i_rst_n) begin
            bg_mode    = 3'd0;
            mosaic_en  = 2'd0;
            bg_height  = 5'd1;
            obj_height = 5'd1;
            x_start    = '0;
            y_start    = '0;
            x_step     = '0;
            y_step     = Y_STEP_RESET;
            ref_x[0]   = '0;
            ref_x[1]   = '0;
            ref_y[0]   = '0;
            ref_y[1]   = '0;
            bg_row     = 4'd0;
            obj_row    = 4'd0;
            line_refs_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_setting(i_paddr[ADDR_W-1:3], i_pwdata);
            if (i_in_valid && !i_in_stall) begin
                step_line(i_in_req, predicted);
                line_refs_q.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (line_refs_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    o_fail_count++;
                end else begin
                    want = line_refs_q.pop_front();
                    check_field("bg2_ref_x", want.bg2_ref_x, i_out_req.bg2_ref_x);
                    check_field("bg2_ref_y", want.bg2_ref_y, i_out_req.bg2_ref_y);
                    check_field("bg3_ref_x", want.bg3_ref_x, i_out_req.bg3_ref_x);
                    check_field("bg3_ref_y", want.bg3_ref_y, i_out_req.bg3_ref_y);
                    check_field("bg_mosaic_line", {28'd0, want.bg_mosaic_line},
                                {28'd0, i_out_req.bg_mosaic_line});
                    check_field("obj_mosaic_line", {28'd0, want.obj_mosaic_line},
                                {28'd0, i_out_req.obj_mosaic_line});
                end
            end
        end
        o_pending <= line_refs_q.size();
    end

endmodule

>>> tb/tb_top.sv
// Top of the affine_reference_line_update testbench: clock, reset, APB setup,
// request and result stall generation, verdict. Depends on arlu_pkg, arlu_ref_checker.
`timescale 1ns / 1ps

module tb_top;
    import arlu_pkg::*;

    localparam int RELOAD_LINE = 192;
    localparam int RAND_ITEMS  = 1525;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_req               i_in_req;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_req              o_out_req;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic idle_on;
    logic stall_on;
    logic hold_out;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    affine_reference_line_update #(
        .RELOAD_LINE(RELOAD_LINE)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req  (o_out_req),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    arlu_ref_checker #(
        .RELOAD_LINE(RELOAD_LINE)
    ) u_ref_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_req   (o_out_req),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [4:0] pick_height();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'($urandom_range(17, 30));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // enters and leaves at a falling edge
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_event(input logic kind, input logic [8:0] line);
        int gap;
        t_in_req req;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.kind        = kind;
        req.line_number = line;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_setup();
        apb_write(REG_BG_MODE, ($urandom_range(0, 4) == 0) ? 64'd0 : 64'($urandom_range(1, 7)));
        apb_write(REG_MOSAIC_EN, 64'($urandom_range(0, 3)));
        apb_write(REG_BG_MOS_H, {59'd0, pick_height()});
        apb_write(REG_OBJ_MOS_H, {59'd0, pick_height()});
        apb_write(REG_X_START, {pick_start(), pick_start()});
        apb_write(REG_Y_START, {pick_start(), pick_start()});
        apb_write(REG_X_STEP, {32'd0, pick_step(), pick_step()});
        apb_write(REG_Y_STEP, {32'd0, pick_step(), pick_step()});
    endtask

    initial begin : out_stall_gen
        int len;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_out = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!stall_on || $urandom_range(0, 3) != 0) begin
                i_out_stall <= 1'b0;
            end else begin
                len = 1 + pick_gap();
                i_out_stall <= 1'b1;
                repeat (len) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int phase_len;
        int k;
        int r;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_on    = 1'b1;
        stall_on   = 1'b1;
        hold_out   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: updates off, heights of one
        send_event(KIND_BLANK, 9'd192);
        send_event(KIND_DRAWN, 9'd5);
        send_event(KIND_BLANK, 9'd0);
        send_event(KIND_BLANK, 9'd262);
        send_event(KIND_DRAWN, 9'd255);
        drain();

        apb_write(REG_BG_MODE, 64'd7);
        apb_write(REG_MOSAIC_EN, 64'd0);
        apb_write(REG_BG_MOS_H, 64'd16);
        apb_write(REG_OBJ_MOS_H, 64'd16);
        apb_write(REG_X_START, 64'h7fff_ffff_8000_0000);
        apb_write(REG_Y_START, 64'hffff_ffff_0000_0001);
        apb_write(REG_X_STEP, 64'h8000_7fff);
        apb_write(REG_Y_STEP, 64'hffff_0001);
        send_event(KIND_BLANK, 9'd192);
        send_event(KIND_DRAWN, 9'd0);
        send_event(KIND_DRAWN, 9'd0);
        send_event(KIND_DRAWN, 9'd0);
        send_event(KIND_BLANK, 9'd191);
        send_event(KIND_BLANK, 9'd193);
        drain();

        // mosaic on both, obj height zero
        apb_write(REG_MOSAIC_EN, 64'd3);
        apb_write(REG_BG_MOS_H, 64'd3);
        apb_write(REG_OBJ_MOS_H, 64'd0);
        repeat (5) send_event(KIND_DRAWN, 9'd100);
        drain();

        // heights above sixteen, mosaic on bg2 only
        apb_write(REG_MOSAIC_EN, 64'd1);
        apb_write(REG_BG_MOS_H, 64'd31);
        apb_write(REG_OBJ_MOS_H, 64'd17);
        apb_write(REG_BG_MODE, 64'd1);
        apb_write(REG_X_STEP, 64'hffff_ffff);
        apb_write(REG_Y_STEP, 64'h8000_8000);
        repeat (4) send_event(KIND_DRAWN, 9'd7);
        send_event(KIND_BLANK, 9'd192);
        repeat (17) send_event(KIND_DRAWN, 9'd7);
        drain();

        apb_write(REG_BG_MODE, 64'd0);
        send_event(KIND_DRAWN, 9'd1);
        send_event(KIND_DRAWN, 9'd2);
        drain();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            random_setup();
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            if (sent == 0) begin
                // back-pressure: sender keeps offering while the result side holds
                idle_on  = 1'b0;
                hold_out = 1'b1;
            end
            phase_len = $urandom_range(40, 160);
            send_event(KIND_BLANK, 9'(RELOAD_LINE));
            for (k = 1; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    send_event(KIND_DRAWN, 9'($urandom_range(0, 262)));
                else if (r < 88)
                    send_event(KIND_BLANK, 9'(RELOAD_LINE));
                else
                    send_event(KIND_BLANK, 9'($urandom_range(0, 262)));
            end
            sent += phase_len;
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/arlu_pkg.sv
rtl/arlu_cfg.sv
rtl/arlu_core.sv
rtl/affine_reference_line_update.sv
tb/arlu_ref_checker.sv
tb/tb_top.sv
